@@ rtl/sap_pkg.sv @@
// Package for the stereo allpass phaser: word types, register indexes,
// datapath operation codes and the build-time coefficient table.
// No dependencies.
`default_nettype none
package sap_pkg;

  localparam int STAGES            = 4;
  localparam int SAMPLE_RATE       = 48000;
  localparam int COEF_TABLE_DEPTH  = 1024;
  localparam int COEF_AW           = $clog2(COEF_TABLE_DEPTH);
  localparam int STG_W             = (STAGES > 1) ? $clog2(STAGES) : 1;

  // register indexes
  localparam logic [1:0] REG_PHASE_INC = 2'd0;
  localparam logic [1:0] REG_FEEDBACK  = 2'd1;
  localparam logic [1:0] REG_ENABLE    = 2'd2;
  localparam logic [1:0] REG_BLOCK_LEN = 2'd3;

  localparam logic [24:0] PHASE_INC_RST = 25'd8948;
  localparam logic [15:0] FEEDBACK_RST  = 16'd22938;
  localparam logic [12:0] BLOCK_LEN_RST = 13'd64;
  localparam logic [12:0] MAX_BLOCK     = 13'd4096;
  localparam logic [31:0] RIGHT_PHASE   = 32'h4000_0000;

  // datapath operations
  localparam logic [3:0] OP_NONE   = 4'd0;
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_MMUL   = 4'd2;
  localparam logic [3:0] OP_ROM    = 4'd3;
  localparam logic [3:0] OP_COEF   = 4'd4;
  localparam logic [3:0] OP_FB     = 4'd5;
  localparam logic [3:0] OP_DIFF   = 4'd6;
  localparam logic [3:0] OP_STAGE  = 4'd7;
  localparam logic [3:0] OP_OUT    = 4'd8;
  localparam logic [3:0] OP_COMMIT = 4'd9;

  typedef struct packed {
    logic signed [15:0] left_in;
    logic signed [15:0] right_in;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
  } out_word_t;

  typedef struct packed {
    logic [3:0]       op;
    logic             ch;
    logic [STG_W-1:0] stg;
  } sap_cmd_t;

  typedef struct packed {
    logic enable;
    logic block_start;
    logic out_free;
  } sap_status_t;

  typedef logic signed [17:0] coef_rom_t [COEF_TABLE_DEPTH];

  localparam longint Q30 = 64'sd1073741824;
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned LN2_Q30     = 64'd744261118;
  // Nyquist clamp, 0.45 of a turn in 2^32 units
  localparam longint unsigned TURNS_LIMIT = (64'd9 << 32) / 64'd20;

  // restoring long division, used only while the table is built
  function automatic longint unsigned udiv64(input longint unsigned n,
                                             input longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[62:0], n[b]};
      q = q << 1;
      if (r >= d) begin
        r = r - d;
        q = q | 64'd1;
      end
    end
    return q;
  endfunction

  // sine of a quarter-wave fraction in Q30
  function automatic longint quarter_sin(input longint unsigned r);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned term;
    longint unsigned dv;
    longint sum;
    sum = 0;
    x = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int k = 1; k <= 5; k++) begin
      dv = longint'(2 * k * (2 * k + 1));
      term = udiv64((term * x2) >> 30, dv);
      if ((k & 1) == 1) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    if (sum < 0) sum = 0;
    if (sum > Q30) sum = Q30;
    return sum;
  endfunction

  // sine of a full-turn fraction u / 2^32
  function automatic longint turn_sin(input logic [31:0] u);
    longint unsigned r;
    longint unsigned q30u;
    r = longint'(u[29:0]);
    q30u = longint'(Q30);
    case (u[31:30])
      2'd0:    return quarter_sin(r);
      2'd1:    return quarter_sin(q30u - r);
      2'd2:    return -quarter_sin(r);
      default: return -quarter_sin(q30u - r);
    endcase
  endfunction

  // 2^f for f in [0,1), Q30
  function automatic longint unsigned exp2_frac(input longint unsigned f);
    longint unsigned y;
    longint unsigned term;
    longint unsigned sum;
    y = (f * LN2_Q30) >> 30;
    term = longint'(Q30);
    sum = longint'(Q30);
    for (int k = 1; k <= 10; k++) begin
      term = udiv64((term * y) >> 30, longint'(k));
      sum = sum + term;
    end
    return sum;
  endfunction

  // sweep, clamp and bilinear warp folded into one Q1.17 coefficient
  function automatic logic signed [17:0] rom_entry(input int i);
    longint unsigned wide;
    logic [31:0] u;
    longint lfo;
    longint unsigned oct;
    longint unsigned e;
    longint unsigned fc;
    longint unsigned turns;
    longint s;
    longint c;
    longint den;
    longint num;
    longint mag;
    longint v;
    int ip;
    // table depth is a power of two, so i * 2^32 / depth is a shift
    wide = longint'(i) << (32 - COEF_AW);
    u = wide[31:0];
    lfo = turn_sin(u);
    oct = longint'(lfo + Q30) >> 1;
    e = 64'd3 * oct;
    ip = int'(e >> 30);
    fc = (64'd200 * exp2_frac(e & 64'h3FFF_FFFF)) << ip;
    turns = udiv64(fc * 64'd4, longint'(SAMPLE_RATE));
    if (turns > TURNS_LIMIT) turns = TURNS_LIMIT;
    s = turn_sin(turns[31:0]);
    wide = turns + longint'(Q30);
    c = turn_sin(wide[31:0]);
    den = Q30 + ((s > 0) ? s : 0);
    num = -c;
    mag = longint'(udiv64(((num < 0) ? -num : num) * 131072 + (den >>> 1), den));
    v = (num < 0) ? -mag : mag;
    if (v > 131071) v = 131071;
    if (v < -131072) v = -131072;
    return v[17:0];
  endfunction

  function automatic coef_rom_t build_rom();
    coef_rom_t t;
    for (int i = 0; i < COEF_TABLE_DEPTH; i++) t[i] = rom_entry(i);
    return t;
  endfunction

endpackage
`default_nettype wire

@@ rtl/sap_ctrl.sv @@
// Phaser sequencer: when enabled, walks each channel through coefficient
// load at block start, feedback, stages and output. Depends on sap_pkg.
`default_nettype none
module sap_ctrl
  import sap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  sap_status_t status,
  output sap_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MMUL = 4'd1;
  localparam logic [3:0] S_ROM  = 4'd2;
  localparam logic [3:0] S_COEF = 4'd3;
  localparam logic [3:0] S_FB   = 4'd4;
  localparam logic [3:0] S_DIFF = 4'd5;
  localparam logic [3:0] S_STG  = 4'd6;
  localparam logic [3:0] S_OUT  = 4'd7;
  localparam logic [3:0] S_DONE = 4'd8;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic             ch;
  logic             ch_next;
  logic [STG_W-1:0] stg;
  logic [STG_W-1:0] stg_next;

  assign sample_stall = (state != S_IDLE);

  // next state and command
  always_comb begin
    state_next = state;
    ch_next    = ch;
    stg_next   = stg;
    cmd.op     = OP_NONE;
    cmd.ch     = ch;
    cmd.stg    = stg;
    case (state)
      S_IDLE: begin
        if (sample_valid) begin
          cmd.op  = OP_LOAD;
          ch_next = 1'b0;
          if (!status.enable) state_next = S_DONE;
          else if (status.block_start) state_next = S_MMUL;
          else state_next = S_FB;
        end
      end
      S_MMUL: begin
        cmd.op = OP_MMUL;
        state_next = S_ROM;
      end
      S_ROM: begin
        cmd.op = OP_ROM;
        state_next = S_COEF;
      end
      S_COEF: begin
        cmd.op = OP_COEF;
        state_next = S_FB;
      end
      S_FB: begin
        cmd.op = OP_FB;
        stg_next = '0;
        state_next = S_DIFF;
      end
      S_DIFF: begin
        cmd.op = OP_DIFF;
        state_next = S_STG;
      end
      S_STG: begin
        cmd.op = OP_STAGE;
        if (stg == STG_W'(STAGES - 1)) begin
          state_next = S_OUT;
        end else begin
          stg_next = stg + 1'b1;
          state_next = S_DIFF;
        end
      end
      S_OUT: begin
        cmd.op = OP_OUT;
        if (!ch) begin
          ch_next = 1'b1;
          state_next = status.block_start ? S_MMUL : S_FB;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.op = OP_COMMIT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ch    <= 1'b0;
      stg   <= '0;
    end else begin
      state <= state_next;
      ch    <= ch_next;
      stg   <= stg_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/sap_datapath.sv @@
// Phaser datapath: configuration, LFO phases, coefficient ROM, two
// multipliers, allpass delays, the result register. Depends on sap_pkg.
`default_nettype none
module sap_datapath
  import sap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data,
  input  in_word_t    sample,
  input  sap_cmd_t    cmd,
  output sap_status_t status,
  output out_word_t   result,
  output logic        result_valid,
  input  logic        result_stall
);

  localparam coef_rom_t ROM = build_rom();

  function automatic logic signed [17:0] sat18(input logic signed [23:0] v);
    if (v > 24'sd131071) return 18'sd131071;
    if (v < -24'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) return 16'sd32767;
    if (v < -21'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // configuration
  logic [24:0] phase_increment;
  logic [15:0] feedback_gain;
  logic        enable;
  logic [12:0] block_length;

  // channel state
  logic [31:0]        lfo_phase [2];
  logic signed [17:0] x1 [2][STAGES];
  logic signed [17:0] y1 [2][STAGES];
  logic signed [17:0] last_wet [2];
  logic signed [17:0] coef [2];
  logic [11:0]        block_pos;

  // working registers
  in_word_t           in_word;
  logic [37:0]        midprod;
  logic signed [17:0] rom_q;
  logic signed [17:0] x;
  logic signed [18:0] d;
  logic signed [15:0] res [2];

  logic [12:0]        len;
  logic [12:0]        pos_inc;
  logic [31:0]        mid;
  logic [COEF_AW-1:0] rom_addr;
  logic signed [17:0] dry;
  logic signed [17:0] mul_a;
  logic signed [18:0] mul_b;
  logic signed [36:0] mul_p;
  logic signed [37:0] p_fb;
  logic signed [37:0] p_stg;
  logic signed [17:0] fb_x;
  logic signed [17:0] stg_y;
  logic signed [23:0] out_sum;
  logic signed [15:0] out_s;

  assign len = (block_length == 13'd0) ? 13'd1 :
               ((block_length > MAX_BLOCK) ? MAX_BLOCK : block_length);
  assign pos_inc = {1'b0, block_pos} + 13'd1;

  assign status.enable      = enable;
  assign status.block_start = (block_pos == 12'd0);
  assign status.out_free    = !result_valid || !result_stall;

  // mid-block phase picks the table entry
  assign mid      = lfo_phase[cmd.ch] + midprod[32:1];
  assign rom_addr = mid[31 -: COEF_AW];

  assign dry = cmd.ch ? 18'(signed'({in_word.right_in, 2'b00}))
                      : 18'(signed'({in_word.left_in, 2'b00}));

  // shared multiplier: feedback scaling or stage coefficient
  assign mul_a = (cmd.op == OP_FB) ? last_wet[cmd.ch] : coef[cmd.ch];
  assign mul_b = (cmd.op == OP_FB) ? signed'({3'b000, feedback_gain}) : d;
  assign mul_p = mul_a * mul_b;

  assign p_fb  = 38'(mul_p) + 38'sd32768;
  assign p_stg = 38'(mul_p) + 38'sd65536;
  assign fb_x  = sat18(24'(dry) + 24'(signed'(p_fb[37:16])));
  assign stg_y = sat18(24'(x1[cmd.ch][cmd.stg]) + 24'(signed'(p_stg[37:17])));

  assign out_sum = 24'(dry) + 24'(x) + 24'sd4;
  assign out_s   = sat16(out_sum[23:3]);

  // working registers, no reset
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD:  in_word <= sample;
      OP_MMUL:  midprod <= 38'(phase_increment) * 38'(len);
      OP_ROM:   rom_q   <= ROM[rom_addr];
      OP_FB:    x       <= fb_x;
      OP_DIFF:  d       <= 19'(x) - 19'(y1[cmd.ch][cmd.stg]);
      OP_STAGE: x       <= stg_y;
      OP_OUT:   res[cmd.ch] <= out_s;
      default: ;
    endcase
  end

  // configuration and channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_increment <= PHASE_INC_RST;
      feedback_gain   <= FEEDBACK_RST;
      enable          <= 1'b1;
      block_length    <= BLOCK_LEN_RST;
      lfo_phase[0]    <= '0;
      lfo_phase[1]    <= RIGHT_PHASE;
      for (int c = 0; c < 2; c++) begin
        last_wet[c] <= '0;
        coef[c]     <= '0;
        for (int s = 0; s < STAGES; s++) begin
          x1[c][s] <= '0;
          y1[c][s] <= '0;
        end
      end
      block_pos    <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          REG_PHASE_INC: phase_increment <= cfg_data;
          REG_FEEDBACK:  feedback_gain   <= cfg_data[15:0];
          REG_ENABLE:    enable          <= cfg_data[0];
          REG_BLOCK_LEN: block_length    <= cfg_data[12:0];
          default: ;
        endcase
      end
      // result held until taken; a commit refills it in the same cycle
      if (cmd.op == OP_COMMIT) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
      case (cmd.op)
        OP_COEF: coef[cmd.ch] <= rom_q;
        OP_STAGE: begin
          x1[cmd.ch][cmd.stg] <= x;
          y1[cmd.ch][cmd.stg] <= stg_y;
        end
        OP_OUT: last_wet[cmd.ch] <= x;
        OP_COMMIT: begin
          lfo_phase[0] <= lfo_phase[0] + {7'd0, phase_increment};
          lfo_phase[1] <= lfo_phase[1] + {7'd0, phase_increment};
          if (enable) begin
            block_pos <= (pos_inc >= len) ? 12'd0 : pos_inc[11:0];
          end else begin
            block_pos <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (cmd.op == OP_COMMIT) begin
      if (enable) begin
        result.left_out  <= res[0];
        result.right_out <= res[1];
      end else begin
        result.left_out  <= in_word.left_in;
        result.right_out <= in_word.right_in;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/stereo_allpass_phaser.sv @@
// Stereo allpass phaser, top level: sequencer plus datapath.
// Each word passes load, feedback, allpass stages and output for both channels
// (coefficient multiply and ROM read added when a block starts), or goes straight
// to commit when disabled. A new word is taken only once the last is committed;
// the sequencer steps one operation per cycle, and a held result adds stalls.
// Reset (rst, synchronous): registers to defaults, phases left 0 / right quarter turn.
`default_nettype none
module stereo_allpass_phaser
  import sap_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        sample_valid,
  output logic        sample_stall,
  input  in_word_t    sample,
  output logic        result_valid,
  input  logic        result_stall,
  output out_word_t   result,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [24:0] cfg_data
);

  sap_cmd_t    cmd;
  sap_status_t status;

  assign cfg_ready = 1'b1;

  sap_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sap_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample       (sample),
    .cmd          (cmd),
    .status       (status),
    .result       (result),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

`ifndef ASSERT_OFF
  // a word taken makes the block busy next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |=> sample_stall)
    else $error("block not busy after taking a word");

  // taking a word loads it into the datapath
  a_load: assert property (@(posedge clk) disable iff (rst)
    (sample_valid && !sample_stall) |-> (cmd.op == OP_LOAD))
    else $error("word taken without load");

  // commit presents a result
  a_commit: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COMMIT) |=> result_valid)
    else $error("commit without result");
`endif

endmodule
`default_nettype wire
